[rtl/llip_pkg.sv]
package llip_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int DATA_W      = 32;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int DIV_STEPS   = PROD_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  // request type codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  // controller -> datapath
  typedef struct packed {
    logic             load_wr;
    logic             take_q;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             lat_lo;
    logic             prep;
    logic             mul;
    logic             div_step;
    logic             out_pass;
    logic             out_interp;
    logic [IDX_W-1:0] seg_idx;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic q_gt;
    logic q_lt;
    logic flat;
    logic out_free;
  } sts_t;

endpackage

[rtl/llip_req_if.sv]
interface llip_req_if import llip_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [IDX_W-1:0]         point_index;
  logic signed [DATA_W-1:0] point_x;
  logic signed [DATA_W-1:0] point_y;
  logic signed [DATA_W-1:0] query_x;

  modport source (output valid, req_type, point_index, point_x, point_y, query_x,
                  input ready);
  modport sink   (input valid, req_type, point_index, point_x, point_y, query_x,
                  output ready);
endinterface

[rtl/llip_res_if.sv]
interface llip_res_if import llip_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] cal_value;
  logic                     passthrough;
  logic                     flat_segment;
  logic [IDX_W-1:0]         segment_index;

  modport source (output valid, cal_value, passthrough, flat_segment, segment_index,
                  input ready);
  modport sink   (input valid, cal_value, passthrough, flat_segment, segment_index,
                  output ready);
endinterface

[rtl/llip_dp.sv]
module llip_dp import llip_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  input  logic [IDX_W-1:0]         point_index_i,
  input  logic signed [DATA_W-1:0] point_x_i,
  input  logic signed [DATA_W-1:0] point_y_i,
  input  logic signed [DATA_W-1:0] query_x_i,
  input  logic                     res_ready_i,
  output logic                     res_valid_o,
  output logic signed [DATA_W-1:0] cal_value_o,
  output logic                     passthrough_o,
  output logic                     flat_segment_o,
  output logic [IDX_W-1:0]         segment_index_o
);

  logic signed [DATA_W-1:0] x_mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] y_mem [TABLE_DEPTH];

  logic signed [DATA_W-1:0] rd_x_q, rd_y_q;
  logic signed [DATA_W-1:0] q_q, x0_q, y0_q;
  logic [DATA_W-1:0]        dx_mag_q, dy_mag_q, dq_mag_q;
  logic                     neg_q, flat_q;
  logic [DATA_W-1:0]        rem_q;
  logic [PROD_W-1:0]        quo_q;
  logic                     res_valid_q;
  logic signed [DATA_W-1:0] cal_q;
  logic                     pass_q, flatseg_q;
  logic [IDX_W-1:0]         seg_q;

  // table: one write port (loads), one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) begin
      x_mem[point_index_i] <= point_x_i;
      y_mem[point_index_i] <= point_y_i;
    end
    if (cmd_i.rd_en) begin
      rd_x_q <= x_mem[cmd_i.rd_addr];
      rd_y_q <= y_mem[cmd_i.rd_addr];
    end
  end

  // segment differences, sign folded out
  logic signed [DATA_W:0] dx_w, dy_w, dq_w;
  logic [DATA_W:0]        dx_abs, dy_abs, dq_abs;

  always_comb begin
    dx_w   = {rd_x_q[DATA_W-1], rd_x_q} - {x0_q[DATA_W-1], x0_q};
    dy_w   = {rd_y_q[DATA_W-1], rd_y_q} - {y0_q[DATA_W-1], y0_q};
    dq_w   = {q_q[DATA_W-1], q_q} - {x0_q[DATA_W-1], x0_q};
    dx_abs = dx_w[DATA_W] ? -dx_w : dx_w;
    dy_abs = dy_w[DATA_W] ? -dy_w : dy_w;
    dq_abs = dq_w[DATA_W] ? -dq_w : dq_w;
  end

  // restoring divider, one quotient bit per step
  logic [DATA_W:0] div_sh, div_diff;
  logic            div_ge;

  always_comb begin
    div_sh   = {rem_q, quo_q[PROD_W-1]};
    div_diff = div_sh - {1'b0, dx_mag_q};
    div_ge   = (div_sh >= {1'b0, dx_mag_q});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_q) begin
      q_q <= query_x_i;
    end
    if (cmd_i.lat_lo) begin
      x0_q <= rd_x_q;
      y0_q <= rd_y_q;
    end
    if (cmd_i.prep) begin
      dx_mag_q <= dx_abs[DATA_W-1:0];
      dy_mag_q <= dy_abs[DATA_W-1:0];
      dq_mag_q <= dq_abs[DATA_W-1:0];
      neg_q    <= dx_w[DATA_W] ^ dy_w[DATA_W] ^ dq_w[DATA_W];
      flat_q   <= (rd_x_q == x0_q);
    end
    if (cmd_i.mul) begin
      quo_q <= PROD_W'(dy_mag_q) * PROD_W'(dq_mag_q);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[PROD_W-2:0], div_ge};
      rem_q <= div_ge ? div_diff[DATA_W-1:0] : div_sh[DATA_W-1:0];
    end
  end

  // final add and saturation
  localparam int SUM_W = DATA_W + 5;
  logic                     quo_zero, quo_big;
  logic signed [SUM_W-1:0]  term_w, sum_w;
  logic signed [DATA_W-1:0] interp_w;

  always_comb begin
    quo_zero = (quo_q == '0);
    quo_big  = (|quo_q[PROD_W-1:35]) || (quo_q[34] && (|quo_q[33:0]));
    term_w   = {2'b00, quo_q[34:0]};
    sum_w    = {{5{y0_q[DATA_W-1]}}, y0_q} + (neg_q ? -term_w : term_w);
    if (flat_q || quo_zero) begin
      interp_w = y0_q;
    end else if (quo_big) begin
      interp_w = neg_q ? S32_MIN : S32_MAX;
    end else if (sum_w[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){sum_w[SUM_W-1]}}) begin
      interp_w = sum_w[SUM_W-1] ? S32_MIN : S32_MAX;
    end else begin
      interp_w = sum_w[DATA_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.out_pass || cmd_i.out_interp) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_pass) begin
      cal_q     <= q_q;
      pass_q    <= 1'b1;
      flatseg_q <= 1'b0;
      seg_q     <= '0;
    end else if (cmd_i.out_interp) begin
      cal_q     <= interp_w;
      pass_q    <= 1'b0;
      flatseg_q <= flat_q;
      seg_q     <= cmd_i.seg_idx;
    end
  end

  assign res_valid_o     = res_valid_q;
  assign cal_value_o     = cal_q;
  assign passthrough_o   = pass_q;
  assign flat_segment_o  = flatseg_q;
  assign segment_index_o = seg_q;

  assign sts_o.q_gt     = (q_q > rd_x_q);
  assign sts_o.q_lt     = (q_q < rd_x_q);
  assign sts_o.flat     = (rd_x_q == x0_q);
  assign sts_o.out_free = !res_valid_q || res_ready_i;

endmodule

[rtl/llip_ctrl.sv]
module llip_ctrl import llip_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             req_valid_i,
  input  logic             req_type_i,
  output logic             req_ready_o,
  output cmd_t             cmd_o,
  input  sts_t             sts_i
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_PASS   = 4'd1;
  localparam logic [3:0] ST_UP_RD  = 4'd2;
  localparam logic [3:0] ST_UP_CMP = 4'd3;
  localparam logic [3:0] ST_DN_RD  = 4'd4;
  localparam logic [3:0] ST_DN_CMP = 4'd5;
  localparam logic [3:0] ST_LD0    = 4'd6;
  localparam logic [3:0] ST_LD1    = 4'd7;
  localparam logic [3:0] ST_PREP   = 4'd8;
  localparam logic [3:0] ST_MUL    = 4'd9;
  localparam logic [3:0] ST_DIV    = 4'd10;
  localparam logic [3:0] ST_FIN    = 4'd11;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  logic [3:0]           state_q, state_d;
  logic [CNT_W-1:0]     cnt_q;
  logic [IDX_W-1:0]     hint_q, hint_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;

  logic [CNT_W-1:0] n_w, n_m1, n_m2, idx_ext;
  logic             accept;

  assign n_w     = (cnt_q > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : cnt_q;
  assign n_m1    = n_w - CNT_W'(1);
  assign n_m2    = n_w - CNT_W'(2);
  assign idx_ext = {1'b0, idx_q};

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    state_d       = state_q;
    hint_d        = hint_q;
    idx_d         = idx_q;
    div_cnt_d     = div_cnt_q;
    cmd_o         = '0;
    cmd_o.rd_addr = idx_q;
    cmd_o.seg_idx = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_LOAD) begin
            cmd_o.load_wr = 1'b1;
            hint_d        = n_w[CNT_W-1:1];
          end else begin
            cmd_o.take_q = 1'b1;
            if (n_w < CNT_W'(2)) begin
              state_d = ST_PASS;
            end else begin
              // a stale hint starts at the last point
              idx_d   = ({1'b0, hint_q} > n_m1) ? n_m1[IDX_W-1:0] : hint_q;
              state_d = ST_UP_RD;
            end
          end
        end
      end
      ST_PASS: begin
        if (sts_i.out_free) begin
          cmd_o.out_pass = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_UP_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_UP_CMP;
      end
      ST_UP_CMP: begin
        if ((idx_ext < n_m1) && sts_i.q_gt) begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_UP_RD;
        end else begin
          state_d = ST_DN_CMP;
        end
      end
      ST_DN_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        if ((idx_q != '0) && sts_i.q_lt) begin
          idx_d   = idx_q - IDX_W'(1);
          state_d = ST_DN_RD;
        end else begin
          idx_d   = (idx_ext > n_m2) ? n_m2[IDX_W-1:0] : idx_q;
          hint_d  = idx_d;
          state_d = ST_LD0;
        end
      end
      ST_LD0: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_LD1;
      end
      ST_LD1: begin
        cmd_o.lat_lo  = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = idx_q + IDX_W'(1);
        state_d       = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = sts_i.flat ? ST_FIN : ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        div_cnt_d = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (div_cnt_q == DIV_LAST) begin
          state_d = ST_FIN;
        end else begin
          div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_interp = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      hint_q    <= '0;
      idx_q     <= '0;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      hint_q    <= hint_d;
      idx_q     <= idx_d;
      div_cnt_q <= div_cnt_d;
      if (cfg_we_i) begin
        cnt_q <= cfg_wdata_i;
      end
    end
  end

`ifndef ASSERT_OFF
  a_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |-> ({1'b0, cmd_o.rd_addr} < n_w))
    else $error("table read beyond points in use");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_pass || cmd_o.out_interp) |-> sts_i.out_free)
    else $error("result written into occupied output register");

  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_cnt_q == DIV_LAST) |=> (state_q == ST_FIN))
    else $error("divider did not finish after last step");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i == REQ_QUERY) |=> !req_ready_o)
    else $error("query accepted without leaving idle");
`endif

endmodule

[rtl/lut_linear_interpolator.sv]
// Piecewise linear calibration table, signed Q16.16.
// Channels: req_i (sink) carries load and query requests, res_o (source)
// carries one result per query; both move a request when valid and ready
// are high at a rising clk_i edge. cfg_we_i/cfg_wdata_i set point_count.
// A load request writes one (x, y) point and re-centers the search hint;
// loads are taken back to back and give no result.
// A query walks from the hinted segment through the table, one point at
// a time (single read port of the x/y memory), then forms the product
// with one 32x32 multiply and divides it by dx with a restoring divider,
// one quotient bit per cycle. A flat segment skips the multiply and the
// divide; with fewer than two points in use the query passes through.
// One query is in flight at a time.
// The output register holds a finished result while the receiver stalls;
// the block returns to idle once the result is placed there.
// Reset (rst_ni low, async) clears point_count, the hint and all control;
// table contents are undefined until loaded.
module lut_linear_interpolator import llip_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  llip_req_if.sink          req_i,
  llip_res_if.source        res_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: search walk, load/divide stepping, hint and count registers
  llip_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // table memory, multiplier, divider, saturation and output register
  llip_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .point_index_i   (req_i.point_index),
    .point_x_i       (req_i.point_x),
    .point_y_i       (req_i.point_y),
    .query_x_i       (req_i.query_x),
    .res_ready_i     (res_o.ready),
    .res_valid_o     (res_o.valid),
    .cal_value_o     (res_o.cal_value),
    .passthrough_o   (res_o.passthrough),
    .flat_segment_o  (res_o.flat_segment),
    .segment_index_o (res_o.segment_index)
  );

endmodule
